### hdl/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Shared codes and types of the segment lock table: operation, lock mode
// and status codes, and the verdict passed from the rule logic to the top.
// ----------------------------------------------------------------------------
package slt_pkg;

  // width of the key field on the request channel
  localparam int SEG_KEY_W = 32;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_UPGRADE = 2'd2,
    OP_CHECK   = 2'd3
  } slt_op_t;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_REORG = 2'd2,
    MODE_EXCL  = 2'd3
  } slt_mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_MISSING   = 3'd2,
    ST_BAD       = 3'd3,
    ST_SATURATED = 3'd4
  } slt_status_t;

  // outcome of one request, as decided by the rule logic
  typedef struct packed {
    logic        granted;
    logic        readers_clear;
    slt_status_t status;
    logic        wr_en;
    logic        valid_new;
  } slt_verdict_t;

endpackage

### hdl/slt_rules.sv
// ----------------------------------------------------------------------------
// slt_rules
// Compatibility rules of the lock table: given the request and the entry
// found by the scan, computes the updated entry fields and the verdict.
// ----------------------------------------------------------------------------
module slt_rules #(
  parameter int COUNT_WIDTH = 8
) (
  input  slt_pkg::slt_op_t         op,
  input  slt_pkg::slt_mode_t       mode,
  input  logic                     hit,
  input  logic                     free_ok,
  input  logic [COUNT_WIDTH-1:0]   rc_i,
  input  logic [COUNT_WIDTH-1:0]   wc_i,
  input  logic                     reorg_i,
  input  logic                     excl_i,
  output logic [COUNT_WIDTH-1:0]   rc_o,
  output logic [COUNT_WIDTH-1:0]   wc_o,
  output logic                     reorg_o,
  output logic                     excl_o,
  output slt_pkg::slt_verdict_t    verdict_o
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  logic alloc;
  logic rel_ok;

  // decision and entry update
  always_comb begin
    rc_o                = rc_i;
    wc_o                = wc_i;
    reorg_o             = reorg_i;
    excl_o              = excl_i;
    alloc               = 1'b0;
    rel_ok              = 1'b0;
    verdict_o.granted   = 1'b0;
    verdict_o.status    = slt_pkg::ST_OK;
    verdict_o.wr_en     = 1'b0;
    verdict_o.valid_new = 1'b1;

    case (op)
      slt_pkg::OP_ACQUIRE: begin
        if (mode == slt_pkg::MODE_EXCL) begin
          verdict_o.status = slt_pkg::ST_BAD;
        end else if (!hit) begin
          if (!free_ok) begin
            verdict_o.status = slt_pkg::ST_FULL;
          end else begin
            // new entry in the lowest free slot
            alloc             = 1'b1;
            rc_o              = (mode == slt_pkg::MODE_READ) ? CNT_ONE : '0;
            wc_o              = (mode == slt_pkg::MODE_WRITE) ? CNT_ONE : '0;
            reorg_o           = (mode == slt_pkg::MODE_REORG);
            excl_o            = 1'b0;
            verdict_o.wr_en   = 1'b1;
            verdict_o.granted = 1'b1;
          end
        end else begin
          case (mode)
            slt_pkg::MODE_READ: begin
              if (!excl_i) begin
                if (rc_i == CNT_MAX) begin
                  verdict_o.status = slt_pkg::ST_SATURATED;
                end else begin
                  rc_o              = rc_i + CNT_ONE;
                  verdict_o.wr_en   = 1'b1;
                  verdict_o.granted = 1'b1;
                end
              end
            end
            slt_pkg::MODE_WRITE: begin
              if (!reorg_i && !excl_i) begin
                if (wc_i == CNT_MAX) begin
                  verdict_o.status = slt_pkg::ST_SATURATED;
                end else begin
                  wc_o              = wc_i + CNT_ONE;
                  verdict_o.wr_en   = 1'b1;
                  verdict_o.granted = 1'b1;
                end
              end
            end
            slt_pkg::MODE_REORG: begin
              if (wc_i == '0 && !reorg_i && !excl_i) begin
                reorg_o           = 1'b1;
                verdict_o.wr_en   = 1'b1;
                verdict_o.granted = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      slt_pkg::OP_RELEASE: begin
        if (!hit) begin
          verdict_o.status = slt_pkg::ST_MISSING;
        end else begin
          case (mode)
            slt_pkg::MODE_READ: begin
              rel_ok = (rc_i != '0);
              rc_o   = rc_i - CNT_ONE;
            end
            slt_pkg::MODE_WRITE: begin
              rel_ok = (wc_i != '0);
              wc_o   = wc_i - CNT_ONE;
            end
            slt_pkg::MODE_REORG: begin
              rel_ok  = reorg_i;
              reorg_o = 1'b0;
            end
            default: begin
              rel_ok = excl_i;
              excl_o = 1'b0;
            end
          endcase
          if (!rel_ok) begin
            rc_o             = rc_i;
            wc_o             = wc_i;
            reorg_o          = reorg_i;
            excl_o           = excl_i;
            verdict_o.status = slt_pkg::ST_BAD;
          end else begin
            // entry is freed once no holder is left
            verdict_o.wr_en     = 1'b1;
            verdict_o.valid_new = !(rc_o == '0 && wc_o == '0 && !reorg_o && !excl_o);
          end
        end
      end

      slt_pkg::OP_UPGRADE: begin
        if (!hit) begin
          verdict_o.status = slt_pkg::ST_MISSING;
        end else if (wc_i != '0 || !reorg_i || excl_i) begin
          verdict_o.status = slt_pkg::ST_BAD;
        end else begin
          reorg_o         = 1'b0;
          excl_o          = 1'b1;
          verdict_o.wr_en = 1'b1;
        end
      end

      default: begin
        // check readers done: no change
        if (!hit) begin
          verdict_o.status = slt_pkg::ST_MISSING;
        end
      end
    endcase

    verdict_o.readers_clear = (!hit && !alloc) || !verdict_o.valid_new || (rc_o == '0);
  end

endmodule

### hdl/segment_lock_table.sv
// Scan: a request found in slot m is answered once the key compare reaches
//   slot m; an absent key scans all TABLE_ENTRIES slots.
// Requests: one at a time; a new one is taken only after the last result
//   is registered. The key compare walks the entry memory one slot per cycle.
// Reset: a clearing pass over all TABLE_ENTRIES slots marks every slot free;
//   no request is taken until it ends.
// ----------------------------------------------------------------------------
// segment_lock_table
// Table of segment locks with read, write, reorg and reorg-exclusive modes.
// A small sequencer scans the entry memory with one shared key comparator,
// then does at most one read-modify-write of the matched or newly allocated entry.
// ----------------------------------------------------------------------------
module segment_lock_table #(
  parameter int TABLE_ENTRIES = 64,
  parameter int KEY_WIDTH     = 32,
  parameter int COUNT_WIDTH   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_segment_key,
  input  logic [1:0]  in_lock_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_granted,
  output logic        out_readers_clear,
  output logic [2:0]  out_status
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

  typedef struct packed {
    logic                   valid;
    logic [KEY_WIDTH-1:0]   key;
    logic [COUNT_WIDTH-1:0] rc;
    logic [COUNT_WIDTH-1:0] wc;
    logic                   reorg;
    logic                   excl;
  } entry_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MODIFY
  } state_t;

  state_t                 state_r;
  logic [IDX_W-1:0]       chk_addr_r;
  slt_pkg::slt_op_t       op_r;
  slt_pkg::slt_mode_t     mode_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic                   hit_r;
  logic [IDX_W-1:0]       hit_idx_r;
  logic [COUNT_WIDTH-1:0] hit_rc_r;
  logic [COUNT_WIDTH-1:0] hit_wc_r;
  logic                   hit_reorg_r;
  logic                   hit_excl_r;
  logic                   free_ok_r;
  logic [IDX_W-1:0]       free_idx_r;
  logic                   out_valid_r;
  logic                   out_granted_r;
  logic                   out_readers_clear_r;
  logic [2:0]             out_status_r;

  entry_t                 mem [TABLE_ENTRIES];
  entry_t                 rd_data_r;
  entry_t                 wr_data;
  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       wr_addr;
  logic                   mem_we;

  logic [KEY_WIDTH-1:0]   key_in;
  logic                   scan_match;
  logic                   out_free;

  logic [COUNT_WIDTH-1:0] new_rc;
  logic [COUNT_WIDTH-1:0] new_wc;
  logic                   new_reorg;
  logic                   new_excl;
  slt_pkg::slt_verdict_t  verdict;

  // key taken as its low KEY_WIDTH bits, or zero-extended when KEY_WIDTH is wider
  if (KEY_WIDTH <= slt_pkg::SEG_KEY_W) begin : g_key_trunc
    assign key_in = in_segment_key[KEY_WIDTH-1:0];
  end else begin : g_key_ext
    assign key_in = {{(KEY_WIDTH - slt_pkg::SEG_KEY_W){1'b0}}, in_segment_key};
  end

  // shared key comparator on the slot under scan
  assign scan_match = rd_data_r.valid && (rd_data_r.key == key_r);
  assign out_free   = !out_valid_r || out_ready;

  // rule evaluation on the captured entry
  slt_rules #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_rules (
    .op        (op_r),
    .mode      (mode_r),
    .hit       (hit_r),
    .free_ok   (free_ok_r),
    .rc_i      (hit_rc_r),
    .wc_i      (hit_wc_r),
    .reorg_i   (hit_reorg_r),
    .excl_i    (hit_excl_r),
    .rc_o      (new_rc),
    .wc_o      (new_wc),
    .reorg_o   (new_reorg),
    .excl_o    (new_excl),
    .verdict_o (verdict)
  );

  // memory port control
  assign rd_addr = (state_r == S_SCAN) ? chk_addr_r + IDX_ONE : '0;
  assign mem_we  = (state_r == S_CLEAR) ||
                   (state_r == S_MODIFY && out_free && verdict.wr_en);
  assign wr_addr = (state_r == S_CLEAR) ? chk_addr_r : (hit_r ? hit_idx_r : free_idx_r);

  always_comb begin
    if (state_r == S_CLEAR) begin
      wr_data = '0;
    end else begin
      wr_data.valid = verdict.valid_new;
      wr_data.key   = key_r;
      wr_data.rc    = new_rc;
      wr_data.wc    = new_wc;
      wr_data.reorg = new_reorg;
      wr_data.excl  = new_excl;
    end
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      chk_addr_r  <= '0;
      hit_r       <= 1'b0;
      free_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // result taken and no new one loaded in its place
      if (out_valid_r && out_ready && state_r != S_MODIFY) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          if (chk_addr_r == LAST_IDX) begin
            chk_addr_r <= '0;
            state_r    <= S_IDLE;
          end else begin
            chk_addr_r <= chk_addr_r + IDX_ONE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r       <= slt_pkg::slt_op_t'(in_operation);
            mode_r     <= slt_pkg::slt_mode_t'(in_lock_mode);
            key_r      <= key_in;
            hit_r      <= 1'b0;
            free_ok_r  <= 1'b0;
            chk_addr_r <= '0;
            state_r    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // remember the lowest free slot
          if (!rd_data_r.valid && !free_ok_r) begin
            free_ok_r  <= 1'b1;
            free_idx_r <= chk_addr_r;
          end
          if (scan_match) begin
            hit_r       <= 1'b1;
            hit_idx_r   <= chk_addr_r;
            hit_rc_r    <= rd_data_r.rc;
            hit_wc_r    <= rd_data_r.wc;
            hit_reorg_r <= rd_data_r.reorg;
            hit_excl_r  <= rd_data_r.excl;
            state_r     <= S_MODIFY;
          end else if (chk_addr_r == LAST_IDX) begin
            state_r <= S_MODIFY;
          end else begin
            chk_addr_r <= chk_addr_r + IDX_ONE;
          end
        end
        S_MODIFY: begin
          if (out_free) begin
            out_valid_r         <= 1'b1;
            out_granted_r       <= verdict.granted;
            out_readers_clear_r <= verdict.readers_clear;
            out_status_r        <= verdict.status;
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_granted       = out_granted_r;
  assign out_readers_clear = out_readers_clear_r;
  assign out_status        = out_status_r;

`ifndef SYNTHESIS
  // a result appears only from the update step
  a_result_from_modify: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_MODIFY))
    else $error("result raised outside the update step");

  // a key match ends the scan at once
  a_match_stops_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && scan_match) |=> (state_r == S_MODIFY))
    else $error("scan continued past a matching entry");

  // the scan never runs beyond the last slot
  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && chk_addr_r == LAST_IDX) |=> (state_r != S_SCAN))
    else $error("scan ran beyond the last slot");

  // a grant always carries an ok status
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_granted_r) |-> (out_status_r == slt_pkg::ST_OK))
    else $error("grant reported with an error status");
`endif

endmodule
